// ===== hw/rtl/vlhe_pkg.sv =====
package vlhe_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned HDR_BITS  = 4;
    localparam int unsigned PAYLOAD_W = VALUE_W - HDR_BITS;  // 60
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned FULL_BYTES = PAYLOAD_W / BYTE_W; // 7 whole bytes + one nibble

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    // Number of bytes needed to carry the payload: index of the highest
    // nonzero byte plus one, zero for an all-zero payload.
    function automatic logic [CNT_W-1:0] payload_bytes(input logic [PAYLOAD_W-1:0] sv);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < FULL_BYTES; i++) begin
            if (sv[BYTE_W*i +: BYTE_W] != '0) begin
                n = CNT_W'(i + 1);
            end
        end
        if (sv[PAYLOAD_W-1:BYTE_W*FULL_BYTES] != '0) begin
            n = CNT_W'(FULL_BYTES + 1);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/varint64_length_header_encoder.sv =====
// Length-prefixed varint encoder for 64-bit unsigned values. Each accepted
// value is sent as 1 to 9 bytes on the byte channel, header byte first: the
// header's upper nibble is the count of extra bytes, its lower nibble the
// value's low 4 bits; the extra bytes carry value >> 4, least significant
// byte first, and last marks the final byte. Both channels use valid/stall;
// a transfer happens on a clock edge with valid high and stall low. The
// block works on one value at a time: value_stall stays high from the
// accepting edge until the transfer of the last byte. One byte leaves per
// cycle while byte_stall is low; the extra bytes come from a single 60-bit
// shift register that drops 8 bits per byte.
module varint64_length_header_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         value_valid,
    output logic                         value_stall,
    input  logic [vlhe_pkg::VALUE_W-1:0] value,
    output logic                         byte_valid,
    input  logic                         byte_stall,
    output logic [vlhe_pkg::BYTE_W-1:0]  out_byte,
    output logic                         last
);
    import vlhe_pkg::*;

    state_t                 state_reg, state_next;
    logic [PAYLOAD_W-1:0]   shift_reg, shift_next;   // remaining payload
    logic [CNT_W-1:0]       left_reg, left_next;     // extra bytes still queued
    logic [BYTE_W-1:0]      byte_reg, byte_next;     // byte on the output
    logic                   last_reg, last_next;
    logic [CNT_W-1:0]       extra;

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = value_valid && (state_reg == ST_IDLE);
    assign out_xfer = (state_reg == ST_EMIT) && !byte_stall;

    // Extra byte count from the nonzero bytes of value >> 4
    assign extra = payload_bytes(value[VALUE_W-1:HDR_BITS]);

    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // Header goes straight to the output register
                    state_next = ST_EMIT;
                    shift_next = value[VALUE_W-1:HDR_BITS];
                    left_next  = extra;
                    byte_next  = {extra, value[HDR_BITS-1:0]};
                    last_next  = (extra == '0);
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Shared shifter: next payload byte, then drop it
                        byte_next  = shift_reg[BYTE_W-1:0];
                        shift_next = {{BYTE_W{1'b0}}, shift_reg[PAYLOAD_W-1:BYTE_W]};
                        left_next  = left_reg - CNT_W'(1);
                        last_next  = (left_reg == CNT_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= '0;
            shift_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            shift_reg <= shift_next;
            last_reg  <= last_next;
        end
    end

    // Output byte needs no reset; qualified by byte_valid
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign value_stall = (state_reg != ST_IDLE);
    assign byte_valid  = (state_reg == ST_EMIT);
    assign out_byte    = byte_reg;
    assign last        = last_reg;

endmodule

// ===== hw/rtl/vlhe_checker.sv =====
module vlhe_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         value_valid,
    input logic                         value_stall,
    input logic [vlhe_pkg::VALUE_W-1:0] value,
    input logic                         byte_valid,
    input logic                         byte_stall,
    input logic [vlhe_pkg::BYTE_W-1:0]  out_byte,
    input logic                         last
);
    import vlhe_pkg::*;

    // Header follows the accepted value: low nibble copied, count at most 8
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (value_valid && !value_stall) |=>
            (byte_valid && out_byte[HDR_BITS-1:0] == $past(value[HDR_BITS-1:0])
             && out_byte[BYTE_W-1:HDR_BITS] <= 4'd8))
        else $error("header byte does not match accepted value");

    // A zero value gives a single zero byte
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (value_valid && !value_stall && value == '0) |=> (out_byte == '0 && last))
        else $error("zero value not encoded as one zero byte");

    // No new value taken while bytes are pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid |-> value_stall)
        else $error("input accepted during emission");

    // Byte channel goes quiet after the last transfer
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && last) |=> !byte_valid)
        else $error("byte_valid held after final transfer");

    // Stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_stall) |=> (byte_valid && $stable(out_byte) && $stable(last)))
        else $error("stalled byte changed");

endmodule

bind varint64_length_header_encoder vlhe_checker u_vlhe_checker (.*);
